// ===== src/dqs_pkg.sv =====
// Shared constants, codes and ring index helper for the double-ended queue.
`default_nettype none

package dqs_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_BACK   = 2'd2,
    CMD_SEARCH     = 2'd3
  } dqs_cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4
  } dqs_status_e;

  function automatic logic [AW-1:0] dqs_wrap(input logic [AW-1:0] base,
                                             input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/dqs_if.sv =====
// Request and response channel interfaces of the double-ended queue.
`default_nettype none

interface dqs_cmd_if;
  import dqs_pkg::*;
  logic                       valid;
  logic                       ready;
  dqs_cmd_e                   command;
  logic signed [DATA_W-1:0]   value;
  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface dqs_rsp_if;
  import dqs_pkg::*;
  logic                       valid;
  logic                       ready;
  dqs_status_e                status;
  logic signed [DATA_W-1:0]   removed_value;
  logic [COUNT_W-1:0]         count;
  modport source (output valid, status, removed_value, count, input ready);
  modport sink   (input valid, status, removed_value, count, output ready);
endinterface

`default_nettype wire

// ===== src/deque_with_search.sv =====
// Top level: ring-buffer double-ended queue with front-to-back search.
`default_nettype none

// A bounded double-ended queue of 32-bit values kept in one synchronous RAM.
// Each request yields one response with a status, the removed value and the
// length after the request. Inserts and rejected or empty requests finish in
// the execute step once the output register is free; a removal first waits in a
// read-wait state on the RAM read. A search reads one entry per cycle through
// the single RAM read port until it meets a match or the last entry. One request
// is worked on at a time; a new request is taken while the previous response
// still waits in the output register. No clearing pass follows reset.
module deque_with_search (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dqs_cmd_if.sink   cmd_i,
  dqs_rsp_if.source rsp_o
);
  import dqs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_SCAN   = 2'd3;

  logic [1:0]              state_q, state_d;
  dqs_cmd_e                cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]           front_q, front_d;
  logic [CNT_W-1:0]        occ_q, occ_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic                    rsp_valid_q, rsp_valid_d;
  dqs_status_e             status_q, status_d;
  logic [DATA_W-1:0]       removed_q, removed_d;
  logic [COUNT_W-1:0]      count_q, count_d;

  logic                    out_free, full, empty, finish;
  dqs_status_e             fin_status;
  logic [DATA_W-1:0]       fin_removed;
  logic [AW-1:0]           front_dec;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;

  dqs_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W),
    .ADDR_W(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(val_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign full      = (occ_q == CNT_W'(CAPACITY));
  assign empty     = (occ_q == '0);
  assign front_dec = (front_q == '0) ? AW'(CAPACITY - 1) : AW'(front_q - 1'b1);
  assign cmd_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    front_d     = front_q;
    occ_d       = occ_q;
    scan_d      = scan_q;
    finish      = 1'b0;
    fin_status  = ST_DONE;
    fin_removed = '0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = dqs_wrap(front_q, occ_q);
    ram_raddr   = front_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.command;
          val_d   = cmd_i.value;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (out_free) begin
              finish = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ram_we = 1'b1;
                occ_d  = occ_q + 1'b1;
                if (cmd_q == CMD_PUSH_FRONT) begin
                  front_d   = front_dec;
                  ram_waddr = front_dec;
                end
              end
            end
          end
          CMD_POP_BACK: begin
            if (empty) begin
              if (out_free) begin
                finish     = 1'b1;
                fin_status = ST_EMPTY;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = dqs_wrap(front_q, occ_q - 1'b1);
              state_d   = S_RDWAIT;
            end
          end
          default: begin
            if (empty) begin
              if (out_free) begin
                finish     = 1'b1;
                fin_status = ST_NOTFOUND;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = front_q;
              scan_d    = CNT_W'(1);
              state_d   = S_SCAN;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        if (out_free) begin
          finish      = 1'b1;
          fin_removed = ram_rdata;
          occ_d       = occ_q - 1'b1;
        end
      end
      S_SCAN: begin
        if (ram_rdata == val_q) begin
          if (out_free) begin
            finish     = 1'b1;
            fin_status = ST_FOUND;
          end
        end else if (scan_q == occ_q) begin
          if (out_free) begin
            finish     = 1'b1;
            fin_status = ST_NOTFOUND;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dqs_wrap(front_q, scan_q);
          scan_d    = scan_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      state_d = S_IDLE;
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, occ_d};

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    removed_d   = removed_q;
    count_d     = count_q;
    if (finish) begin
      rsp_valid_d = 1'b1;
      status_d    = fin_status;
      removed_d   = fin_removed;
      count_d     = cnt_ext[COUNT_W-1:0];
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      scan_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    val_q     <= val_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    count_q   <= count_d;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.count         = count_q;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && fin_status == ST_DONE &&
     (cmd_q == CMD_PUSH_FRONT || cmd_q == CMD_PUSH_BACK))
    |=> occ_q == CNT_W'($past(occ_q) + 1'b1))
    else $error("insert did not grow the queue");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_q != '0 && scan_q <= occ_q))
    else $error("search offset out of range");

  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC && !ram_re))
    else $error("RAM write outside execute step");

  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> rsp_valid_q)
    else $error("response lost");
`endif

endmodule

`default_nettype wire

// ===== src/dqs_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module dqs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
